FILE: sv/gb3_pkg.sv
// ----------------------------------------------------------------------------
// gb3_pkg: shared types and constants of the 3x3 blur stream
// Word layouts, configuration register indexes and datapath widths.
// ----------------------------------------------------------------------------
package gb3_pkg;

  localparam int PIX_W   = 8;
  localparam int COL_W   = 3 * PIX_W;   // one window column: upper, middle, lower
  localparam int WGT_W   = 16;          // unsigned Q0.16 weight
  localparam int CFG_W   = 16;          // widest configuration register
  localparam int CFG_IDX_W = 3;
  localparam int LW_W    = 13;          // line_width register
  localparam int VSUM_W  = 26;          // vertical sum of one column
  localparam int SIDE_W  = VSUM_W + 1;  // left plus right vertical sums
  localparam int PROD_E_W = WGT_W + SIDE_W;
  localparam int PROD_C_W = WGT_W + VSUM_W;
  localparam int TOTAL_W = PROD_E_W + 1;
  localparam int FRAC_SH = 32;          // Q0.16 times Q0.16

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_CENTER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_EDGE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_CENTER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_EDGE     = 3'd4;

  localparam logic [LW_W-1:0]  LINE_WIDTH_RST = 13'd640;
  localparam logic [WGT_W-1:0] CENTER_WGT_RST = 16'd34210;
  localparam logic [WGT_W-1:0] EDGE_WGT_RST   = 16'd15663;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             stream_end;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             line_last;
    logic             stream_done;
  } out_word_t;

  // Per-item decisions, taken when the word is accepted.
  typedef struct packed {
    logic stream_end;
    logic emit_pix;
    logic blur_ok;
    logic emit_last;
    logic last;
  } item_flags_t;

  // Up to two result words handed to the output queue in one cycle.
  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } out_push_t;

endpackage

FILE: sv/gaussian_blur_3x3_stream.sv
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_stream: streaming separable 3x3 blur of 8-bit pixels
// Line stores, a chain of three column cells and a two-stage weighted sum.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the pix channel (pix_valid/pix_ready/pix_word) in raster
//   order; a word with stream_end set yields one marker word and changes no
//   state. Results leave on the blur channel (blur_valid/blur_ready/blur_word)
//   one column behind the input. Line 0 gives nothing, line 1 gives zeros,
//   later lines give the blur with both border columns at zero; the last
//   column of each line adds a zero word with line_last set.
//   Pixels pass one at a time through accept, line store write with
//   window shift, vertical sums, horizontal products and result push,
//   paced by the registered line store read and the two multiplier stages.
//   An end-of-stream word goes from accept straight to the result push;
//   results leave from the registered result queue.
//   Reset: counters, window columns and the result queue clear, registers
//   take their default values; line store contents stay undefined.
//   Stall: the two-word result queue lets the next pixel be accepted while
//   results wait; the push stage holds until the queue has room.
//   The user writes configuration on cfg_we/cfg_index/cfg_data while idle;
//   the block itself does not enforce this.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_stream #(
  parameter int MAX_LINE_WIDTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gb3_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            pix_valid,
  output logic                            pix_ready,
  input  gb3_pkg::in_word_t               pix_word,
  output logic                            blur_valid,
  input  logic                            blur_ready,
  output gb3_pkg::out_word_t              blur_word
);
  import gb3_pkg::*;

  localparam int CW = (MAX_LINE_WIDTH > 2) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int NCELL = 3;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MEM  = 5'b00010,
    ST_VERT = 5'b00100,
    ST_HORZ = 5'b01000,
    ST_SUM  = 5'b10000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [LW_W-1:0]  line_width;
  logic [WGT_W-1:0] x_center_weight, x_edge_weight;
  logic [WGT_W-1:0] y_center_weight, y_edge_weight;

  // stream position
  logic [1:0]    line_count;
  logic [CW-1:0] col_count;

  // accepted word
  logic [PIX_W-1:0] pix;
  item_flags_t      flags, flags_next;

  // window and datapath
  logic [2*PIX_W-1:0]  store_rd;
  logic [COL_W-1:0]    cur_col;
  logic [COL_W-1:0]    cell_col [NCELL];
  logic [COL_W-1:0]    cell_in  [NCELL];
  logic [VSUM_W-1:0]   cell_vsum [NCELL];
  logic [SIDE_W-1:0]   side_sum;
  logic [PROD_E_W-1:0] prod_side;
  logic [PROD_C_W-1:0] prod_mid;
  logic [TOTAL_W-1:0]  total;
  logic [TOTAL_W-FRAC_SH-1:0] total_hi;
  logic [PIX_W-1:0]    blur_pix;

  logic [31:0]   width_eff;
  logic [CW-1:0] width_m1;
  logic          accept, cur_last;
  logic [1:0]    need, q_count;
  out_push_t     push;
  out_word_t     pix_res, last_res;

  assign accept    = pix_valid && pix_ready;
  assign pix_ready = (state == ST_IDLE);

  // Clamp the width to 3 .. MAX_LINE_WIDTH; a counter at or past the last
  // column closes the line.
  always_comb begin
    width_eff = {{(32-LW_W){1'b0}}, line_width};
    if (width_eff < 32'd3) begin
      width_eff = 32'd3;
    end
    if (width_eff > 32'(MAX_LINE_WIDTH)) begin
      width_eff = 32'(MAX_LINE_WIDTH);
    end
  end
  assign width_m1 = CW'(width_eff - 32'd1);
  assign cur_last = (col_count >= width_m1);

  always_comb begin
    flags_next.stream_end = pix_word.stream_end;
    flags_next.emit_pix   = (line_count != 2'd0) && (col_count != '0);
    flags_next.blur_ok    = (line_count == 2'd2) && (col_count >= CW'(2));
    flags_next.emit_last  = (line_count != 2'd0) && cur_last;
    flags_next.last       = cur_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width      <= LINE_WIDTH_RST;
      x_center_weight <= CENTER_WGT_RST;
      x_edge_weight   <= EDGE_WGT_RST;
      y_center_weight <= CENTER_WGT_RST;
      y_edge_weight   <= EDGE_WGT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_WIDTH: line_width      <= cfg_data[LW_W-1:0];
        CFG_X_CENTER:   x_center_weight <= cfg_data;
        CFG_X_EDGE:     x_edge_weight   <= cfg_data;
        CFG_Y_CENTER:   y_center_weight <= cfg_data;
        CFG_Y_EDGE:     y_edge_weight   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: one pixel at a time; the marker skips straight to the push.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = pix_word.stream_end ? ST_SUM : ST_MEM;
        end
      end
      ST_MEM:  state_next = ST_VERT;
      ST_VERT: state_next = ST_HORZ;
      ST_HORZ: state_next = ST_SUM;
      ST_SUM: begin
        if ({1'b0, q_count} + {1'b0, need} <= 3'd2) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the accepted word for the rest of its pass.
  always_ff @(posedge clk) begin
    if (accept) begin
      pix   <= pix_word.pixel_in;
      flags <= flags_next;
    end
  end

  // Advance the column and line counters as the stores are written.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= 2'd0;
      col_count  <= '0;
    end else if (state == ST_MEM) begin
      if (flags.last) begin
        col_count <= '0;
        if (line_count != 2'd2) begin
          line_count <= line_count + 2'd1;
        end
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  gb3_line_store #(
    .DEPTH (MAX_LINE_WIDTH),
    .AW    (CW)
  ) u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (store_rd),
    .wr_en   (state == ST_MEM),
    .wr_addr (col_count),
    .wr_data ({store_rd[PIX_W-1:0], pix})
  );

  // New column: older line on top, newer line in the middle, this pixel below.
  assign cur_col = {store_rd, pix};

  // Cell 0 takes the new column, cell 1 the middle, cell 2 the left one.
  assign cell_in[0] = cur_col;
  assign cell_in[1] = cell_col[0];
  assign cell_in[2] = cell_col[1];

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    gb3_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (state == ST_MEM),
      .calc     (state == ST_VERT),
      .col_in   (cell_in[k]),
      .y_edge   (y_edge_weight),
      .y_center (y_center_weight),
      .col      (cell_col[k]),
      .vsum     (cell_vsum[k])
    );
  end

  // Horizontal weights: edge columns share one multiplier.
  assign side_sum = {1'b0, cell_vsum[2]} + {1'b0, cell_vsum[0]};

  always_ff @(posedge clk) begin
    if (state == ST_HORZ) begin
      prod_side <= {{SIDE_W{1'b0}}, x_edge_weight} * {{WGT_W{1'b0}}, side_sum};
      prod_mid  <= {{VSUM_W{1'b0}}, x_center_weight} * {{WGT_W{1'b0}}, cell_vsum[1]};
    end
  end

  // Drop the fraction and clip at full scale.
  assign total    = {1'b0, prod_side} + {{(TOTAL_W-PROD_C_W){1'b0}}, prod_mid};
  assign total_hi = total[TOTAL_W-1:FRAC_SH];
  assign blur_pix = (total_hi > {{(TOTAL_W-FRAC_SH-PIX_W){1'b0}}, {PIX_W{1'b1}}})
                    ? {PIX_W{1'b1}} : total_hi[PIX_W-1:0];

  always_comb begin
    pix_res.pixel_out   = flags.blur_ok ? blur_pix : '0;
    pix_res.line_last   = 1'b0;
    pix_res.stream_done = 1'b0;
    last_res.pixel_out   = '0;
    last_res.line_last   = !flags.stream_end;
    last_res.stream_done = flags.stream_end;

    if (flags.stream_end) begin
      need = 2'd1;
    end else begin
      need = {1'b0, flags.emit_pix} + {1'b0, flags.emit_last};
    end

    push.count  = 2'd0;
    push.first  = flags.emit_pix && !flags.stream_end ? pix_res : last_res;
    push.second = last_res;
    if (state == ST_SUM && ({1'b0, q_count} + {1'b0, need} <= 3'd2)) begin
      push.count = need;
    end
  end

  gb3_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .count      (q_count),
    .blur_valid (blur_valid),
    .blur_ready (blur_ready),
    .blur_word  (blur_word)
  );

endmodule

FILE: sv/gb3_cell.sv
// ----------------------------------------------------------------------------
// gb3_cell: one column cell of the 3x3 window
// Holds a window column, hands it to the next cell and forms its weighted
// vertical sum with the current vertical weights.
// ----------------------------------------------------------------------------
module gb3_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        shift,
  input  logic                        calc,
  input  logic [gb3_pkg::COL_W-1:0]   col_in,
  input  logic [gb3_pkg::WGT_W-1:0]   y_edge,
  input  logic [gb3_pkg::WGT_W-1:0]   y_center,
  output logic [gb3_pkg::COL_W-1:0]   col,
  output logic [gb3_pkg::VSUM_W-1:0]  vsum
);
  import gb3_pkg::*;

  logic [PIX_W:0]                edge_sum;
  logic [WGT_W+PIX_W:0]          prod_e;
  logic [WGT_W+PIX_W-1:0]        prod_c;
  logic [VSUM_W-1:0]             vsum_next;

  assign edge_sum  = {1'b0, col[COL_W-1 -: PIX_W]} + {1'b0, col[PIX_W-1:0]};
  assign prod_e    = {{(PIX_W+1){1'b0}}, y_edge} * {{WGT_W{1'b0}}, edge_sum};
  assign prod_c    = {{PIX_W{1'b0}}, y_center} * {{WGT_W{1'b0}}, col[2*PIX_W-1 -: PIX_W]};
  assign vsum_next = {1'b0, prod_e} + {2'b0, prod_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (calc) begin
      vsum <= vsum_next;
    end
  end

endmodule

FILE: sv/gb3_line_store.sv
// ----------------------------------------------------------------------------
// gb3_line_store: the two line stores of the blur
// One entry per column holds the older and the newer line side by side;
// read data is registered.
// ----------------------------------------------------------------------------
module gb3_line_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [2*gb3_pkg::PIX_W-1:0]   rd_data,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [2*gb3_pkg::PIX_W-1:0]   wr_data
);
  import gb3_pkg::*;

  logic [2*PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/gb3_out_fifo.sv
// ----------------------------------------------------------------------------
// gb3_out_fifo: two-word result queue
// Takes up to two words per cycle and releases one per handshake.
// ----------------------------------------------------------------------------
module gb3_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  gb3_pkg::out_push_t  push,
  output logic [1:0]          count,
  output logic                blur_valid,
  input  logic                blur_ready,
  output gb3_pkg::out_word_t  blur_word
);
  import gb3_pkg::*;

  out_word_t  ent0, ent1, ent0_next, ent1_next;
  logic [1:0] count_next;
  logic       pop;

  assign blur_valid = (count != 2'd0);
  assign blur_word  = ent0;
  assign pop        = blur_valid && blur_ready;

  always_comb begin
    ent0_next  = ent0;
    ent1_next  = ent1;
    count_next = count;
    if (pop) begin
      ent0_next  = ent1;
      count_next = count_next - 2'd1;
    end
    if (push.count != 2'd0) begin
      if (count_next == 2'd0) begin
        ent0_next = push.first;
      end else begin
        ent1_next = push.first;
      end
      count_next = count_next + 2'd1;
    end
    if (push.count == 2'd2) begin
      ent1_next  = push.second;
      count_next = count_next + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ent0 <= ent0_next;
    ent1 <= ent1_next;
  end

endmodule
